@@ rtl/assert_macros.svh @@
// Assertion helpers used by the checker in spsm_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// When pre holds, post must hold at the next clock edge.
`define ASSERT_NEXT(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

@@ rtl/spsm_pkg.sv @@
package spsm_pkg;

	typedef enum logic [1:0] {
		PH_SILENCE = 2'd0,
		PH_PENDING = 2'd1,
		PH_SPEECH  = 2'd2
	} phase_t;

	localparam logic [1:0] MODE_FRAME = 2'd0;
	localparam logic [1:0] MODE_FLUSH = 2'd1;
	localparam logic [1:0] MODE_RESET = 2'd2;

	localparam logic [1:0] CAUSE_SILENCE = 2'd0;
	localparam logic [1:0] CAUSE_MAX_LEN = 2'd1;
	localparam logic [1:0] CAUSE_FLUSH   = 2'd2;
	localparam logic [1:0] CAUSE_UNUSED  = 2'd3;

	localparam int CFG_ADDR_W = 2;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_ADDR_W-1:0] REG_MIN_SPEECH  = 2'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_MIN_SILENCE = 2'd1;
	localparam logic [CFG_ADDR_W-1:0] REG_SEG_CAP     = 2'd2;

	localparam logic [CFG_DATA_W-1:0] RST_MIN_SPEECH  = 16'd16;
	localparam logic [CFG_DATA_W-1:0] RST_MIN_SILENCE = 16'd31;
	localparam logic [CFG_DATA_W-1:0] RST_SEG_CAP     = 16'd1875;

	localparam int IN_TDATA_W  = 8;
	localparam int OUT_TDATA_W = 72;

	// Output tdata field positions.
	localparam int OUT_START_LSB = 0;
	localparam int OUT_END_LSB   = 32;
	localparam int OUT_CAUSE_LSB = 64;
	localparam int OUT_STATE_LSB = 66;

endpackage

@@ rtl/speech_segment_state_machine.sv @@
// A transaction accepted at the input is held in the input register, then moves into the
// result register, which drives the result port until the result side takes it.
// Throughput: one item per cycle; the input register and result register form a
// two-stage pipeline that keeps moving while the result side takes its transactions.
// Reset (arst_n low, asynchronous): pipeline empty, segmenter state and frame index
// cleared, configuration registers back to 16, 31 and 1875.
module speech_segment_state_machine #(
	parameter int INDEX_BITS = 32,
	parameter int COUNT_BITS = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [spsm_pkg::CFG_ADDR_W-1:0]      cfg_addr,
	input  logic [spsm_pkg::CFG_DATA_W-1:0]      cfg_wdata,
	input  logic                                 s_axis_tvalid,
	output logic                                 s_axis_tready,
	// [1:0] mode, [2] speech_flag, [7:3] zero
	input  logic [spsm_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
	output logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	// [31:0] segment_start, [63:32] segment_end, [65:64] end_cause,
	// [67:66] seg_state, [71:68] zero
	output logic [spsm_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
	// [0] segment_done
	output logic                                 m_axis_tuser
);

	localparam int CW = (COUNT_BITS > spsm_pkg::CFG_DATA_W) ? COUNT_BITS : spsm_pkg::CFG_DATA_W;
	localparam int XW = (INDEX_BITS > 32) ? INDEX_BITS : 32;

	// Configuration registers.
	logic [spsm_pkg::CFG_DATA_W-1:0] min_speech_q, min_silence_q, seg_cap_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_speech_q  <= spsm_pkg::RST_MIN_SPEECH;
			min_silence_q <= spsm_pkg::RST_MIN_SILENCE;
			seg_cap_q     <= spsm_pkg::RST_SEG_CAP;
		end else if (cfg_we) begin
			case (cfg_addr)
				spsm_pkg::REG_MIN_SPEECH:  min_speech_q  <= cfg_wdata;
				spsm_pkg::REG_MIN_SILENCE: min_silence_q <= cfg_wdata;
				spsm_pkg::REG_SEG_CAP:     seg_cap_q     <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Input register.
	logic       valid_s1;
	logic [1:0] mode_s1;
	logic       flag_s1;
	logic       advance;
	logic       out_valid_q;

	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			mode_s1 <= s_axis_tdata[1:0];
			flag_s1 <= s_axis_tdata[2];
		end
	end

	// Segmenter state.
	spsm_pkg::phase_t        phase_q, phase_d;
	logic [INDEX_BITS-1:0]   pending_start_q, pending_start_d;
	logic [INDEX_BITS-1:0]   confirmed_start_q, confirmed_start_d;
	logic [INDEX_BITS-1:0]   last_speech_q, last_speech_d;
	logic [INDEX_BITS-1:0]   frame_index_q, frame_index_d;
	logic [COUNT_BITS-1:0]   speech_run_q, speech_run_d;
	logic [COUNT_BITS-1:0]   silence_run_q, silence_run_d;
	logic [COUNT_BITS-1:0]   speech_total_q, speech_total_d;

	logic                    done_d;
	logic [1:0]              cause_d;
	logic [INDEX_BITS-1:0]   end_index;
	logic [XW-1:0]           start_ext, end_ext;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q           <= spsm_pkg::PH_SILENCE;
			pending_start_q   <= '0;
			confirmed_start_q <= '0;
			last_speech_q     <= '0;
			frame_index_q     <= '0;
			speech_run_q      <= '0;
			silence_run_q     <= '0;
			speech_total_q    <= '0;
		end else if (advance) begin
			phase_q           <= phase_d;
			pending_start_q   <= pending_start_d;
			confirmed_start_q <= confirmed_start_d;
			last_speech_q     <= last_speech_d;
			frame_index_q     <= frame_index_d;
			speech_run_q      <= speech_run_d;
			silence_run_q     <= silence_run_d;
			speech_total_q    <= speech_total_d;
		end
	end

	always_comb begin
		logic [COUNT_BITS-1:0] run_inc, sil_inc, tot_inc;
		run_inc = (&speech_run_q)   ? speech_run_q   : speech_run_q + 1'b1;
		sil_inc = (&silence_run_q)  ? silence_run_q  : silence_run_q + 1'b1;
		tot_inc = (&speech_total_q) ? speech_total_q : speech_total_q + 1'b1;

		phase_d           = phase_q;
		pending_start_d   = pending_start_q;
		confirmed_start_d = confirmed_start_q;
		last_speech_d     = last_speech_q;
		frame_index_d     = frame_index_q;
		speech_run_d      = speech_run_q;
		silence_run_d     = silence_run_q;
		speech_total_d    = speech_total_q;
		done_d            = 1'b0;
		cause_d           = spsm_pkg::CAUSE_SILENCE;

		case (mode_s1)
			spsm_pkg::MODE_FRAME: begin
				case (phase_q)
					spsm_pkg::PH_SILENCE: begin
						if (flag_s1) begin
							pending_start_d = frame_index_q;
							speech_run_d    = COUNT_BITS'(1);
							silence_run_d   = '0;
							if (CW'(1) >= CW'(min_speech_q)) begin
								confirmed_start_d = frame_index_q;
								last_speech_d     = frame_index_q;
								speech_total_d    = COUNT_BITS'(1);
								phase_d           = spsm_pkg::PH_SPEECH;
							end else begin
								phase_d = spsm_pkg::PH_PENDING;
							end
						end
					end
					spsm_pkg::PH_PENDING: begin
						if (flag_s1) begin
							speech_run_d  = run_inc;
							silence_run_d = '0;
							if (CW'(run_inc) >= CW'(min_speech_q)) begin
								confirmed_start_d = pending_start_q;
								last_speech_d     = frame_index_q;
								speech_total_d    = run_inc;
								phase_d           = spsm_pkg::PH_SPEECH;
							end
						end else begin
							speech_run_d = '0;
							phase_d      = spsm_pkg::PH_SILENCE;
						end
					end
					spsm_pkg::PH_SPEECH: begin
						if (flag_s1) begin
							speech_total_d = tot_inc;
							last_speech_d  = frame_index_q;
							silence_run_d  = '0;
							if (CW'(tot_inc) >= CW'(seg_cap_q)) begin
								done_d  = 1'b1;
								cause_d = spsm_pkg::CAUSE_MAX_LEN;
							end
						end else begin
							silence_run_d = sil_inc;
							if (CW'(sil_inc) >= CW'(min_silence_q)) begin
								done_d  = 1'b1;
								cause_d = spsm_pkg::CAUSE_SILENCE;
							end
						end
					end
					default: ;
				endcase
				frame_index_d = frame_index_q + 1'b1;
			end
			spsm_pkg::MODE_FLUSH: begin
				if (phase_q == spsm_pkg::PH_SPEECH) begin
					done_d  = 1'b1;
					cause_d = spsm_pkg::CAUSE_FLUSH;
				end
				phase_d       = spsm_pkg::PH_SILENCE;
				speech_run_d  = '0;
				silence_run_d = '0;
			end
			spsm_pkg::MODE_RESET: begin
				phase_d           = spsm_pkg::PH_SILENCE;
				pending_start_d   = '0;
				confirmed_start_d = '0;
				last_speech_d     = '0;
				frame_index_d     = '0;
				speech_run_d      = '0;
				silence_run_d     = '0;
				speech_total_d    = '0;
			end
			default: ;
		endcase

		// Closing a segment drops back to silence and clears both runs.
		if (done_d) begin
			phase_d       = spsm_pkg::PH_SILENCE;
			speech_run_d  = '0;
			silence_run_d = '0;
		end
	end

	assign end_index = last_speech_d + 1'b1;
	assign start_ext = XW'(confirmed_start_d);
	assign end_ext   = XW'(end_index);

	// Result register.
	logic        done_q;
	logic [31:0] start_q, end_q;
	logic [1:0]  cause_q, state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			done_q  <= done_d;
			start_q <= done_d ? start_ext[31:0] : 32'd0;
			end_q   <= done_d ? end_ext[31:0] : 32'd0;
			cause_q <= done_d ? cause_d : spsm_pkg::CAUSE_SILENCE;
			state_q <= phase_d;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = done_q;
	assign m_axis_tdata  = {4'd0, state_q, cause_q, end_q, start_q};

endmodule

@@ rtl/spsm_checker.sv @@
`include "assert_macros.svh"

module spsm_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              m_axis_tvalid,
	input logic                              m_axis_tready,
	input logic [spsm_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
	input logic                              m_axis_tuser
);

	logic [1:0]  cause;
	logic [1:0]  state;
	logic [31:0] seg_start, seg_end;

	assign seg_start = m_axis_tdata[spsm_pkg::OUT_START_LSB +: 32];
	assign seg_end   = m_axis_tdata[spsm_pkg::OUT_END_LSB +: 32];
	assign cause     = m_axis_tdata[spsm_pkg::OUT_CAUSE_LSB +: 2];
	assign state     = m_axis_tdata[spsm_pkg::OUT_STATE_LSB +: 2];

	// A closed segment always leaves the segmenter in silence.
	`ASSERT_ALWAYS(a_done_silence, !(m_axis_tvalid && m_axis_tuser) || state == spsm_pkg::PH_SILENCE, "segment closed but state is not silence")

	// Without a closed segment the segment fields read as zero.
	`ASSERT_ALWAYS(a_idle_zero, !(m_axis_tvalid && !m_axis_tuser) || (seg_start == 32'd0 && seg_end == 32'd0 && cause == spsm_pkg::CAUSE_SILENCE), "segment fields not zero without a closed segment")

	// The unused cause code never shows up.
	`ASSERT_ALWAYS(a_cause_code, !m_axis_tvalid || cause != spsm_pkg::CAUSE_UNUSED, "invalid end cause")

	// A stalled result transaction holds its payload.
	`ASSERT_NEXT(a_stall_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "result changed while stalled")

endmodule

bind speech_segment_state_machine spsm_checker u_spsm_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);

@@ dv/segment_checker.sv @@
`timescale 1ns / 1ps
module segment_checker
	import spsm_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_ADDR_W-1:0]  cfg_addr,
	input  logic [CFG_DATA_W-1:0]  cfg_wdata,
	input  logic                   s_axis_tvalid,
	input  logic                   s_axis_tready,
	// [1:0] mode, [2] speech_flag, [7:3] zero
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
	input  logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	// [31:0] segment_start, [63:32] segment_end, [65:64] end_cause,
	// [67:66] seg_state, [71:68] zero
	input  logic [OUT_TDATA_W-1:0] m_axis_tdata,
	// [0] segment_done
	input  logic                   m_axis_tuser,
	output int                     mismatch_count,
	output int                     segments_outstanding
);

	typedef struct packed {
		logic        done;
		logic [31:0] first_frame;
		logic [31:0] end_frame;
		logic [1:0]  cause;
		phase_t      state;
	} segment_report_t;

	logic [15:0] min_speech;
	logic [15:0] min_silence;
	logic [15:0] seg_cap;

	phase_t      phase;
	logic [31:0] pending_start;
	logic [31:0] confirmed_start;
	logic [31:0] last_speech;
	logic [31:0] frame_index;
	logic [15:0] speech_run;
	logic [15:0] silence_run;
	logic [15:0] speech_total;

	segment_report_t expected_segments[$];

	function automatic logic [15:0] bump(input logic [15:0] v);
		return (v == 16'hFFFF) ? v : v + 16'd1;
	endfunction

	function automatic void clear_state();
		phase = PH_SILENCE;
		pending_start = '0;
		confirmed_start = '0;
		last_speech = '0;
		frame_index = '0;
		speech_run = '0;
		silence_run = '0;
		speech_total = '0;
	endfunction

	function automatic void confirm_start();
		confirmed_start = pending_start;
		last_speech = frame_index;
		speech_total = speech_run;
		phase = PH_SPEECH;
	endfunction

	function automatic segment_report_t closed(input logic [1:0] cause);
		segment_report_t rep;
		rep.done = 1'b1;
		rep.first_frame = confirmed_start;
		rep.end_frame = last_speech + 32'd1;
		rep.cause = cause;
		rep.state = PH_SILENCE;
		phase = PH_SILENCE;
		speech_run = '0;
		silence_run = '0;
		return rep;
	endfunction

	// Advances the segmenter by one transaction and returns what it should report.
	function automatic segment_report_t step_segmenter(input logic [1:0] mode, input logic flag);
		segment_report_t rep;
		rep = '0;
		case (mode)
			MODE_FRAME: begin
				case (phase)
					PH_SILENCE: begin
						if (flag) begin
							pending_start = frame_index;
							speech_run = 16'd1;
							silence_run = '0;
							if (speech_run >= min_speech) confirm_start();
							else phase = PH_PENDING;
						end
					end
					PH_PENDING: begin
						if (flag) begin
							speech_run = bump(speech_run);
							silence_run = '0;
							if (speech_run >= min_speech) confirm_start();
						end else begin
							speech_run = '0;
							phase = PH_SILENCE;
						end
					end
					default: begin
						if (flag) begin
							speech_total = bump(speech_total);
							last_speech = frame_index;
							silence_run = '0;
							if (speech_total >= seg_cap) rep = closed(CAUSE_MAX_LEN);
						end else begin
							silence_run = bump(silence_run);
							if (silence_run >= min_silence) rep = closed(CAUSE_SILENCE);
						end
					end
				endcase
				frame_index = frame_index + 32'd1;
			end
			MODE_FLUSH: begin
				if (phase == PH_SPEECH) rep = closed(CAUSE_FLUSH);
				phase = PH_SILENCE;
				speech_run = '0;
				silence_run = '0;
			end
			MODE_RESET: clear_state();
			default: ;
		endcase
		rep.state = phase;
		return rep;
	endfunction

	function automatic void check_field(input string label, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, label, want, got);
			mismatch_count++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		segment_report_t want;
		if (!arst_n) begin
			min_speech = RST_MIN_SPEECH;
			min_silence = RST_MIN_SILENCE;
			seg_cap = RST_SEG_CAP;
			clear_state();
			expected_segments.delete();
		end else begin
			// Results are compared before this edge's input is predicted, since an
			// input can never produce its own result in the same cycle.
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_segments.size() == 0) begin
					$display("%0t ns: result transaction with nothing expected, tdata %0h tuser %0b",
						$time, m_axis_tdata, m_axis_tuser);
					mismatch_count++;
				end else begin
					want = expected_segments.pop_front();
					check_field("segment_done", 32'(want.done), 32'(m_axis_tuser));
					check_field("segment_start", want.first_frame,
						m_axis_tdata[OUT_START_LSB +: 32]);
					check_field("segment_end", want.end_frame, m_axis_tdata[OUT_END_LSB +: 32]);
					check_field("end_cause", 32'(want.cause),
						32'(m_axis_tdata[OUT_CAUSE_LSB +: 2]));
					check_field("seg_state", 32'(want.state),
						32'(m_axis_tdata[OUT_STATE_LSB +: 2]));
					check_field("tdata padding", '0,
						32'(m_axis_tdata[OUT_TDATA_W-1:OUT_STATE_LSB+2]));
				end
			end
			if (cfg_we) begin
				case (cfg_addr)
					REG_MIN_SPEECH:  min_speech = cfg_wdata;
					REG_MIN_SILENCE: min_silence = cfg_wdata;
					REG_SEG_CAP:     seg_cap = cfg_wdata;
					default: ;
				endcase
			end
			if (s_axis_tvalid && s_axis_tready)
				expected_segments.push_back(step_segmenter(s_axis_tdata[1:0], s_axis_tdata[2]));
		end
		segments_outstanding = expected_segments.size();
	end

endmodule

@@ dv/tb_speech_segment_state_machine.sv @@
`timescale 1ns / 1ps
module tb_speech_segment_state_machine;
	import spsm_pkg::*;

	localparam logic [1:0] MODE_IDLE = 2'd3;
	localparam logic [CFG_ADDR_W-1:0] REG_SPARE = 2'd3;
	localparam int STALL_LIMIT = 500;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_ADDR_W-1:0] cfg_addr = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [IN_TDATA_W-1:0] s_axis_tdata = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic m_axis_tuser;

	int mismatch_count;
	int segments_outstanding;

	logic rx_took = 1'b0;
	logic tx_calm = 1'b0;
	logic rx_calm = 1'b0;
	int items_sent = 0;
	int idle_cycles = 0;
	int sp_limit = int'(RST_MIN_SPEECH);
	int sil_limit = int'(RST_MIN_SILENCE);

	speech_segment_state_machine dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_addr(cfg_addr),
		.cfg_wdata(cfg_wdata),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser)
	);

	segment_checker u_segment_checker (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_addr(cfg_addr),
		.cfg_wdata(cfg_wdata),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.mismatch_count(mismatch_count),
		.segments_outstanding(segments_outstanding)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) rx_took <= m_axis_tvalid && m_axis_tready;

	// Result side: after each transaction, drop ready for a random stall, or keep it high in a calm phase.
	initial begin
		int stall;
		stall = 0;
		forever begin
			@(negedge clk);
			if (rx_took) begin
				if ($urandom_range(0, 31) == 0) rx_calm = !rx_calm;
				stall = rx_calm ? 0 : $urandom_range(0, 7);
			end
			if (stall > 0) begin
				m_axis_tready <= 1'b0;
				stall--;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || cfg_we || (s_axis_tvalid && s_axis_tready) ||
				(m_axis_tvalid && m_axis_tready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("%0t ns: no transaction for %0d cycles", $time, STALL_LIMIT);
			$display("speech_segment_state_machine test failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	task automatic send_item(input logic [1:0] mode, input logic flag);
		int gap;
		if ($urandom_range(0, 31) == 0) tx_calm = !tx_calm;
		gap = tx_calm ? 0 : $urandom_range(0, 7);
		repeat (gap) begin
			@(negedge clk);
			s_axis_tvalid <= 1'b0;
		end
		@(negedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {5'b0, flag, mode};
		do @(posedge clk); while (!s_axis_tready);
		if (mode != MODE_IDLE) items_sent++;
	endtask

	// Drops valid and waits until every expected result has been taken.
	task automatic drain();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		wait (segments_outstanding == 0);
		repeat (3) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr, input logic [CFG_DATA_W-1:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_addr <= addr;
		cfg_wdata <= value;
	endtask

	// The spare index is written too; the block must ignore it.
	task automatic program_limits(input logic [15:0] sp, input logic [15:0] sil,
			input logic [15:0] mx);
		drain();
		write_reg(REG_MIN_SPEECH, sp);
		write_reg(REG_SPARE, CFG_DATA_W'($urandom_range(0, 65535)));
		write_reg(REG_MIN_SILENCE, sil);
		write_reg(REG_SEG_CAP, mx);
		@(negedge clk);
		cfg_we <= 1'b0;
		sp_limit = int'(sp);
		sil_limit = int'(sil);
	endtask

	function automatic int span(input int limit);
		return (limit + 3 > 48) ? 48 : limit + 3;
	endfunction

	// Mostly speech runs followed by silence runs sized around the thresholds,
	// mixed with flushes, hard resets, ignored items and scattered frames.
	task automatic run_traffic(input int budget);
		int target;
		int len;
		int pick;
		target = items_sent + budget;
		while (items_sent < target) begin
			pick = $urandom_range(0, 99);
			if (pick < 70) begin
				len = $urandom_range(1, span(sp_limit));
				repeat (len) send_item(MODE_FRAME, 1'b1);
				len = $urandom_range(1, span(sil_limit));
				repeat (len) send_item(MODE_FRAME, 1'b0);
			end else if (pick < 80) begin
				send_item(MODE_FLUSH, 1'($urandom_range(0, 1)));
			end else if (pick < 84) begin
				send_item(MODE_RESET, 1'($urandom_range(0, 1)));
			end else if (pick < 88) begin
				send_item(MODE_IDLE, 1'($urandom_range(0, 1)));
			end else begin
				len = $urandom_range(1, 6);
				repeat (len) send_item(MODE_FRAME, 1'($urandom_range(0, 1)));
			end
		end
	endtask

	initial begin
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Reset limits: ignored item, flush and reset outside speech, pending runs.
		send_item(MODE_IDLE, 1'b1);
		send_item(MODE_FLUSH, 1'b0);
		send_item(MODE_FRAME, 1'b0);
		send_item(MODE_FRAME, 1'b1);
		send_item(MODE_FRAME, 1'b1);
		send_item(MODE_IDLE, 1'b0);
		send_item(MODE_FLUSH, 1'b1);
		send_item(MODE_FRAME, 1'b1);
		send_item(MODE_FRAME, 1'b0);
		send_item(MODE_FRAME, 1'b1);
		send_item(MODE_RESET, 1'b0);
		run_traffic(300);

		// Short limits: close on maximum length, on silence and on flush.
		program_limits(16'd2, 16'd2, 16'd4);
		repeat (4) send_item(MODE_FRAME, 1'b1);
		repeat (2) send_item(MODE_FRAME, 1'b1);
		repeat (2) send_item(MODE_FRAME, 1'b0);
		repeat (2) send_item(MODE_FRAME, 1'b1);
		send_item(MODE_FRAME, 1'b0);
		send_item(MODE_IDLE, 1'b1);
		send_item(MODE_FLUSH, 1'b0);
		repeat (2) send_item(MODE_FRAME, 1'b1);
		send_item(MODE_RESET, 1'b1);

		program_limits(16'd2, 16'd3, 16'd5);
		run_traffic(130);
		program_limits(16'd0, 16'd0, 16'd0);
		run_traffic(130);
		program_limits(16'd1, 16'd1, 16'd1);
		run_traffic(130);
		// Cap below the confirmation length.
		program_limits(16'd3, 16'd2, 16'd1);
		run_traffic(130);
		program_limits(16'hFFFF, 16'hFFFF, 16'hFFFF);
		run_traffic(130);
		program_limits(16'd4, 16'd6, 16'd40);
		run_traffic(130);
		program_limits(16'd1, 16'hFFFF, 16'hFFFF);
		run_traffic(130);
		program_limits(16'hFFFF, 16'd1, 16'd1);
		run_traffic(130);
		repeat (3) begin
			program_limits(16'($urandom_range(1, 8)), 16'($urandom_range(1, 10)),
				16'($urandom_range(1, 30)));
			run_traffic(130);
		end

		drain();
		repeat (8) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("speech_segment_state_machine test passed");
		end else begin
			$display("speech_segment_state_machine test failed");
		end
		$finish;
	end

endmodule
